FILE: rtl/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg: shared types, codes and helper functions
// Request codes, Q16.16 constants, CORDIC angle table and the elementary
// matrix builder used by the homogeneous transform engine.
// ----------------------------------------------------------------------------
package hte_pkg;

    typedef logic signed [31:0] q16_t;

    localparam logic [2:0] REQ_TRANSLATE = 3'd0;
    localparam logic [2:0] REQ_ROTATE    = 3'd1;
    localparam logic [2:0] REQ_SCALE     = 3'd2;
    localparam logic [2:0] REQ_POINT     = 3'd3;
    localparam logic [2:0] REQ_IDENTITY  = 3'd4;

    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_Y   = 2'd1;
    localparam logic [1:0] AXIS_Z   = 2'd2;
    localparam logic [1:0] AXIS_BAD = 2'd3;

    localparam q16_t ONE_Q   = 32'sd65536;
    localparam q16_t DEG90_Q = 32'sd5898240;
    localparam q16_t DEG180_Q = 32'sd11796480;
    localparam q16_t DEG360_Q = 32'sd23592960;
    // 360 degrees times 128, added once to make any angle non-negative
    localparam logic [31:0] DEG360_X128 = 32'd3019898880;
    localparam q16_t CORDIC_GAIN_Q = 32'sd39797;
    localparam q16_t Q_MAX = 32'sh7fffffff;
    localparam q16_t Q_MIN = 32'sh80000000;

    // atan(2^-i) in degrees, Q16.16
    function automatic q16_t atan_deg(input logic [4:0] i);
        q16_t r;
        case (i)
            5'd0:  r = 32'sd2949120;
            5'd1:  r = 32'sd1740967;
            5'd2:  r = 32'sd919879;
            5'd3:  r = 32'sd466945;
            5'd4:  r = 32'sd234379;
            5'd5:  r = 32'sd117304;
            5'd6:  r = 32'sd58666;
            5'd7:  r = 32'sd29335;
            5'd8:  r = 32'sd14668;
            5'd9:  r = 32'sd7334;
            5'd10: r = 32'sd3667;
            5'd11: r = 32'sd1833;
            5'd12: r = 32'sd917;
            5'd13: r = 32'sd458;
            5'd14: r = 32'sd229;
            5'd15: r = 32'sd115;
            5'd16: r = 32'sd57;
            5'd17: r = 32'sd29;
            5'd18: r = 32'sd14;
            5'd19: r = 32'sd7;
            5'd20: r = 32'sd4;
            5'd21: r = 32'sd2;
            5'd22: r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    function automatic q16_t sat32(input logic signed [49:0] v);
        q16_t r;
        if (v > 50'sd2147483647)
            r = Q_MAX;
        else if (v < -50'sd2147483648)
            r = Q_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // Entry idx (row-major) of the elementary matrix for a request
    function automatic q16_t elem_e(input logic [2:0] req, input logic [1:0] axis,
                                    input logic [3:0] idx, input q16_t vx,
                                    input q16_t vy, input q16_t vz,
                                    input q16_t s, input q16_t c);
        q16_t r;
        r = (idx == 4'd0 || idx == 4'd5 || idx == 4'd10 || idx == 4'd15) ? ONE_Q : '0;
        case (req)
            REQ_TRANSLATE:
            begin
                if (idx == 4'd3)  r = vx;
                if (idx == 4'd7)  r = vy;
                if (idx == 4'd11) r = vz;
            end
            REQ_SCALE:
            begin
                if (idx == 4'd0)  r = vx;
                if (idx == 4'd5)  r = vy;
                if (idx == 4'd10) r = vz;
            end
            REQ_ROTATE:
            begin
                case (axis)
                    AXIS_X:
                    begin
                        if (idx == 4'd5 || idx == 4'd10) r = c;
                        if (idx == 4'd6) r = -s;
                        if (idx == 4'd9) r = s;
                    end
                    AXIS_Y:
                    begin
                        if (idx == 4'd0 || idx == 4'd10) r = c;
                        if (idx == 4'd2) r = s;
                        if (idx == 4'd8) r = -s;
                    end
                    AXIS_Z:
                    begin
                        if (idx == 4'd0 || idx == 4'd5) r = c;
                        if (idx == 4'd1) r = -s;
                        if (idx == 4'd4) r = s;
                    end
                    default: r = r;
                endcase
            end
            default: r = r;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/homogeneous_transform_engine.sv
// ----------------------------------------------------------------------------
// homogeneous_transform_engine: 4x4 Q16.16 transform with perspective
// Keeps a current matrix, composes translate/rotate/scale into it on one
// shared multiply-accumulate unit and transforms and projects points.
// ----------------------------------------------------------------------------
//  channel   dir   signals                       content
//  s_*       in    s_tvalid s_tready s_tdata     request beat (tuser = req_type)
//  m_*       out   m_tvalid m_tready m_tdata     result beat (tuser = flags)
//  cfg_*     in    cfg_we cfg_wdata              persp_distance write
//
//  One request at a time through one 32x32 multiplier. Composition computes
//  the 16 elements in turn; a rotation first runs angle reduction and
//  folding and CORDIC_ITERS CORDIC steps. A point takes four MAC dot
//  products plus two restoring divisions.
//  Reset loads the identity matrix and d = 100. s_tready is low while a
//  request is in work; the result waits in m_tdata until m_tready.
// ----------------------------------------------------------------------------
module homogeneous_transform_engine #(
    parameter int CORDIC_ITERS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // in_x[31:0], in_y[63:32], in_z[95:64], angle_deg[127:96], rot_axis[129:128]
    input  logic [135:0] s_tdata,
    // req_type[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z, out_w, proj_x, proj_y, 32 bits each from the bottom
    output logic [191:0] m_tdata,
    // div_zero[0], status[1]
    output logic [1:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RED   = 4'd1;
    localparam logic [3:0] S_FOLD  = 4'd2;
    localparam logic [3:0] S_CORD  = 4'd3;
    localparam logic [3:0] S_APPLY = 4'd4;
    localparam logic [3:0] S_MAC   = 4'd5;
    localparam logic [3:0] S_PMUL  = 4'd6;
    localparam logic [3:0] S_PCHK  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_PEND  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    localparam logic [5:0] CORD_LAST = 6'(CORDIC_ITERS - 1);

    logic [3:0]  state_reg;
    logic signed [15:0] dist_reg;
    hte_pkg::q16_t mat_reg [16];
    hte_pkg::q16_t row_reg [3];
    logic        has_reg;

    logic [2:0]  req_reg;
    logic [1:0]  axis_reg;
    hte_pkg::q16_t vx_reg, vy_reg, vz_reg;

    logic [31:0] ang_reg;
    logic        flip_reg;
    hte_pkg::q16_t cx_reg, cy_reg, cz_reg;
    logic [5:0]  step_reg;

    logic [3:0]  elem_reg;
    logic [2:0]  cnt_reg;
    logic signed [63:0] prod_reg;
    logic signed [49:0] acc_reg;

    logic        sel_reg;
    logic        neg_reg, ovf_reg;
    logic [31:0] dabs_reg, rem_reg, quo_reg;

    hte_pkg::q16_t ox_reg, oy_reg, oz_reg, ow_reg, px_reg, py_reg;
    logic        dz_reg, st_reg;

    // combinational
    hte_pkg::q16_t sin_v, cos_v;
    logic        point_mode;
    logic [1:0]  row_i, col_j, kk;
    hte_pkg::q16_t mul_a, mul_b;
    logic signed [63:0] prod_rnd;
    logic signed [49:0] acc_sum;
    hte_pkg::q16_t mac_val;
    logic [32:0] red_thr;
    hte_pkg::q16_t fold_a;
    hte_pkg::q16_t cdx, cdy;
    logic signed [32:0] den;
    logic signed [63:0] num;
    logic [63:0] num_abs;
    logic [32:0] trial;
    logic        qbit;
    hte_pkg::q16_t proj_v;

    assign sin_v = flip_reg ? -cy_reg : cy_reg;
    assign cos_v = flip_reg ? -cx_reg : cx_reg;

    assign point_mode = (req_reg == hte_pkg::REQ_POINT);
    assign row_i = point_mode ? elem_reg[1:0] : elem_reg[3:2];
    assign col_j = elem_reg[1:0];
    assign kk    = cnt_reg[1:0];

    always_comb
    begin
        mul_a = mat_reg[{row_i, kk}];
        mul_b = hte_pkg::elem_e(req_reg, axis_reg, {kk, col_j}, vx_reg, vy_reg, vz_reg,
                                sin_v, cos_v);
        if (point_mode)
        begin
            case (kk)
                2'd0:    mul_b = vx_reg;
                2'd1:    mul_b = vy_reg;
                2'd2:    mul_b = vz_reg;
                default: mul_b = hte_pkg::ONE_Q;
            endcase
        end
        if (state_reg == S_PMUL)
        begin
            mul_a = sel_reg ? oy_reg : ox_reg;
            mul_b = 32'(dist_reg);
        end
    end

    assign prod_rnd = prod_reg + 64'sd32768;
    assign acc_sum  = acc_reg + 50'($signed(prod_rnd[63:16]));
    assign mac_val  = hte_pkg::sat32(acc_sum);

    assign red_thr = 33'(hte_pkg::DEG360_Q) << step_reg[2:0];

    always_comb
    begin
        fold_a = (ang_reg > 32'(hte_pkg::DEG180_Q)) ? $signed(ang_reg) - hte_pkg::DEG360_Q
                                                    : $signed(ang_reg);
    end

    assign cdx = cy_reg >>> step_reg;
    assign cdy = cx_reg >>> step_reg;

    assign den     = $signed({dist_reg[15], dist_reg, 16'd0}) - 33'(oz_reg);
    assign num     = prod_reg <<< 16;
    assign num_abs = num[63] ? 64'(-num) : 64'(num);
    assign trial   = {rem_reg, quo_reg[31]};
    assign qbit    = (trial >= {1'b0, dabs_reg});

    always_comb
    begin
        if (ovf_reg)
            proj_v = neg_reg ? hte_pkg::Q_MIN : hte_pkg::Q_MAX;
        else if (neg_reg)
            proj_v = (quo_reg > 32'h80000000) ? hte_pkg::Q_MIN : -$signed(quo_reg);
        else
            proj_v = quo_reg[31] ? hte_pkg::Q_MAX : $signed(quo_reg);
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {py_reg, px_reg, ow_reg, oz_reg, oy_reg, ox_reg};
    assign m_tuser  = {st_reg, dz_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dist_reg <= 16'sd100;
        else if (cfg_we)
            dist_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            has_reg   <= 1'b0;
            for (int n = 0; n < 16; n++)
                mat_reg[n] <= (n % 5 == 0) ? hte_pkg::ONE_Q : '0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        req_reg  <= s_tuser;
                        vx_reg   <= s_tdata[31:0];
                        vy_reg   <= s_tdata[63:32];
                        vz_reg   <= s_tdata[95:64];
                        axis_reg <= s_tdata[129:128];
                        ox_reg <= '0; oy_reg <= '0; oz_reg <= '0; ow_reg <= '0;
                        px_reg <= '0; py_reg <= '0; dz_reg <= 1'b0; st_reg <= 1'b0;
                        elem_reg <= '0;
                        cnt_reg  <= '0;
                        acc_reg  <= '0;
                        // bias negative angles by a multiple of 360 degrees
                        ang_reg  <= s_tdata[127] ? s_tdata[127:96] + hte_pkg::DEG360_X128
                                                 : s_tdata[127:96];
                        step_reg <= 6'd7;
                        case (s_tuser)
                            hte_pkg::REQ_TRANSLATE, hte_pkg::REQ_SCALE:
                                state_reg <= S_APPLY;
                            hte_pkg::REQ_ROTATE:
                            begin
                                if (s_tdata[129:128] == hte_pkg::AXIS_BAD)
                                begin
                                    st_reg    <= 1'b1;
                                    state_reg <= S_OUT;
                                end
                                else
                                    state_reg <= S_RED;
                            end
                            hte_pkg::REQ_POINT:
                                state_reg <= S_MAC;
                            hte_pkg::REQ_IDENTITY:
                            begin
                                for (int n = 0; n < 16; n++)
                                    mat_reg[n] <= (n % 5 == 0) ? hte_pkg::ONE_Q : '0;
                                has_reg   <= 1'b0;
                                state_reg <= S_OUT;
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_RED:
                begin
                    if ({1'b0, ang_reg} >= red_thr)
                        ang_reg <= ang_reg - red_thr[31:0];
                    if (step_reg == 6'd0)
                        state_reg <= S_FOLD;
                    else
                        step_reg <= step_reg - 6'd1;
                end
                S_FOLD:
                begin
                    if (fold_a > hte_pkg::DEG90_Q)
                    begin
                        cz_reg   <= fold_a - hte_pkg::DEG180_Q;
                        flip_reg <= 1'b1;
                    end
                    else if (fold_a < -hte_pkg::DEG90_Q)
                    begin
                        cz_reg   <= fold_a + hte_pkg::DEG180_Q;
                        flip_reg <= 1'b1;
                    end
                    else
                    begin
                        cz_reg   <= fold_a;
                        flip_reg <= 1'b0;
                    end
                    cx_reg    <= hte_pkg::CORDIC_GAIN_Q;
                    cy_reg    <= '0;
                    step_reg  <= '0;
                    state_reg <= S_CORD;
                end
                S_CORD:
                begin
                    if (!cz_reg[31])
                    begin
                        cx_reg <= cx_reg - cdx;
                        cy_reg <= cy_reg + cdy;
                        cz_reg <= cz_reg - hte_pkg::atan_deg(step_reg[4:0]);
                    end
                    else
                    begin
                        cx_reg <= cx_reg + cdx;
                        cy_reg <= cy_reg - cdy;
                        cz_reg <= cz_reg + hte_pkg::atan_deg(step_reg[4:0]);
                    end
                    if (step_reg == CORD_LAST)
                        state_reg <= S_APPLY;
                    else
                        step_reg <= step_reg + 6'd1;
                end
                S_APPLY:
                begin
                    if (!has_reg)
                    begin
                        // matrix is identity: load the elementary matrix as is
                        for (int n = 0; n < 16; n++)
                            mat_reg[n] <= hte_pkg::elem_e(req_reg, axis_reg, 4'(n), vx_reg,
                                                          vy_reg, vz_reg, sin_v, cos_v);
                        has_reg   <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    if (cnt_reg == 3'd4)
                    begin
                        acc_reg  <= '0;
                        cnt_reg  <= '0;
                        elem_reg <= elem_reg + 4'd1;
                        if (point_mode)
                        begin
                            case (elem_reg[1:0])
                                2'd0:    ox_reg <= mac_val;
                                2'd1:    oy_reg <= mac_val;
                                2'd2:    oz_reg <= mac_val;
                                default: ow_reg <= mac_val;
                            endcase
                            if (elem_reg[1:0] == 2'd3)
                            begin
                                has_reg   <= 1'b1;
                                sel_reg   <= 1'b0;
                                state_reg <= S_PMUL;
                            end
                        end
                        else
                        begin
                            // hold the row until its last column is done
                            if (col_j == 2'd3)
                            begin
                                mat_reg[{row_i, 2'd0}] <= row_reg[0];
                                mat_reg[{row_i, 2'd1}] <= row_reg[1];
                                mat_reg[{row_i, 2'd2}] <= row_reg[2];
                                mat_reg[{row_i, 2'd3}] <= mac_val;
                            end
                            else
                                row_reg[col_j] <= mac_val;
                            if (elem_reg == 4'd15)
                                state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        if (cnt_reg != 3'd0)
                            acc_reg <= acc_sum;
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_PMUL:
                begin
                    if (den == 33'sd0)
                    begin
                        dz_reg    <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_PCHK;
                end
                S_PCHK:
                begin
                    neg_reg   <= num[63] ^ den[32];
                    dabs_reg  <= den[32] ? 32'(-den) : 32'(den);
                    ovf_reg   <= (num_abs >= {(den[32] ? 32'(-den) : 32'(den)), 32'd0});
                    rem_reg   <= num_abs[63:32];
                    quo_reg   <= num_abs[31:0];
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= qbit ? 32'(trial - {1'b0, dabs_reg}) : trial[31:0];
                    quo_reg <= {quo_reg[30:0], qbit};
                    if (step_reg == 6'd31)
                        state_reg <= S_PEND;
                    else
                        step_reg <= step_reg + 6'd1;
                end
                S_PEND:
                begin
                    if (sel_reg)
                    begin
                        py_reg    <= proj_v;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        px_reg    <= proj_v;
                        sel_reg   <= 1'b1;
                        state_reg <= S_PMUL;
                    end
                end
                S_OUT:
                begin
                    if (m_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
